### rtl/i2cmbe_pkg.sv
// ============================================================================
// I2C master bit engine package
// Phase codes, status codes, command modes and reset values shared by the
// bit engine RTL.
// ============================================================================
package i2cmbe_pkg;

    // Field widths.
    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 5;
    localparam int COUNT_W  = 4;

    // Command modes carried by an input item.
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUS_BUSY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_CHECK = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_FALL  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST_CLAMP = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SP_LOW   = 5'd4;
    localparam logic [PHASE_W-1:0] PH_SP_HI    = 5'd5;
    localparam logic [PHASE_W-1:0] PH_SP_REL   = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WR_SET   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WR_HI    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WR_LO    = 5'd9;
    localparam logic [PHASE_W-1:0] PH_AK_REL   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_AK_HI    = 5'd11;
    localparam logic [PHASE_W-1:0] PH_AK_POLL  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_RD_HI    = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RD_SAMP  = 5'd14;
    localparam logic [PHASE_W-1:0] PH_AO_SET   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_AO_HI    = 5'd16;
    localparam logic [PHASE_W-1:0] PH_AO_LO    = 5'd17;

    // Number of bits in one byte transfer.
    localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Reset value of the ACK poll limit.
    localparam logic [BYTE_W-1:0] POLL_LIMIT_RESET = 8'd50;

endpackage

### rtl/i2c_master_bit_engine_top.sv
// ============================================================================
// I2C master bit engine
// Pin-level I2C master: one input item is one bus tick carrying the sampled
// SDA level and an optional command; one result item per tick gives the SCL
// and SDA levels, busy, done, the received byte and a status.
// ============================================================================
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------------
//  input    | in        | i_valid / o_stall    | i_mode, i_wr_byte, i_send_ack, i_sda_in
//  result   | out       | o_valid / i_stall    | o_scl_level, o_sda_level, o_busy_res,
//           |           |                      | o_done_res, o_rx_byte, o_status
//  config   | in        | i_cfg_we             | i_cfg_data (ack_poll_limit)
//
// One item is accepted per clock while o_stall is low; its result is ready in the
// output register on the next cycle. The sequencer step is a short piece of
// combinational logic between the state registers and the result register.
// Reset is synchronous and active low; it restores the idle bus (both lines
// released) and an ACK poll limit of 50.
// A stalled result holds the input side off only while the result register
// is full and not being taken.
// ============================================================================
module i2c_master_bit_engine_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [i2cmbe_pkg::MODE_W-1:0]     i_mode,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]     i_wr_byte,
    input  logic                              i_send_ack,
    input  logic                              i_sda_in,
    // Result item channel.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_scl_level,
    output logic                              o_sda_level,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic [i2cmbe_pkg::BYTE_W-1:0]     o_rx_byte,
    output logic [i2cmbe_pkg::STATUS_W-1:0]   o_status,
    // Configuration port.
    input  logic                              i_cfg_we,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]     i_cfg_data
);

    // Sequencer state.
    logic [i2cmbe_pkg::PHASE_W-1:0]  r_phase, n_phase;
    logic [i2cmbe_pkg::COUNT_W-1:0]  r_bit_count, n_bit_count;
    logic [i2cmbe_pkg::BYTE_W-1:0]   r_shifter, n_shifter;
    logic [i2cmbe_pkg::BYTE_W-1:0]   r_poll_count, n_poll_count;
    logic                            r_scl, n_scl;
    logic                            r_sda, n_sda;
    logic                            r_ack_choice, n_ack_choice;
    logic [i2cmbe_pkg::STATUS_W-1:0] r_last_status, n_last_status;
    logic [i2cmbe_pkg::BYTE_W-1:0]   r_rx_hold, n_rx_hold;
    logic [i2cmbe_pkg::BYTE_W-1:0]   r_poll_limit;

    // Result register.
    logic                            r_out_valid;
    logic                            r_out_scl;
    logic                            r_out_sda;
    logic                            r_out_busy;
    logic                            r_out_done;
    logic [i2cmbe_pkg::BYTE_W-1:0]   r_out_rx;
    logic [i2cmbe_pkg::STATUS_W-1:0] r_out_status;

    logic                            in_accept;
    logic                            is_cmd;
    logic                            done;
    logic                            rejected;

    // The input side waits only while a full result register is stalled.
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign is_cmd    = (i_mode >= i2cmbe_pkg::MODE_START) &&
                       (i_mode <= i2cmbe_pkg::MODE_READ);

    // One sequencer step per tick.
    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shifter     = r_shifter;
        n_poll_count  = r_poll_count;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_ack_choice  = r_ack_choice;
        n_last_status = r_last_status;
        n_rx_hold     = r_rx_hold;
        done          = 1'b0;
        // A command is rejected unless the engine is idle.
        rejected      = is_cmd && (r_phase != i2cmbe_pkg::PH_IDLE);
        unique case (r_phase)
            i2cmbe_pkg::PH_IDLE: begin
                if (is_cmd) begin
                    n_last_status = i2cmbe_pkg::ST_OK;
                    unique case (i_mode)
                        i2cmbe_pkg::MODE_START: begin
                            n_sda   = 1'b1;
                            n_phase = i2cmbe_pkg::PH_ST_CHECK;
                        end
                        i2cmbe_pkg::MODE_STOP: begin
                            n_scl   = 1'b0;
                            n_phase = i2cmbe_pkg::PH_SP_LOW;
                        end
                        i2cmbe_pkg::MODE_WRITE: begin
                            n_scl       = 1'b0;
                            n_shifter   = i_wr_byte;
                            n_bit_count = '0;
                            n_phase     = i2cmbe_pkg::PH_WR_SET;
                        end
                        i2cmbe_pkg::MODE_READ: begin
                            n_scl        = 1'b0;
                            n_sda        = 1'b1;
                            n_shifter    = '0;
                            n_bit_count  = '0;
                            n_ack_choice = i_send_ack;
                            n_phase      = i2cmbe_pkg::PH_RD_HI;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            i2cmbe_pkg::PH_ST_CHECK: begin
                if (!i_sda_in) begin
                    n_last_status = i2cmbe_pkg::ST_BUS_BUSY;
                    done          = 1'b1;
                    n_phase       = i2cmbe_pkg::PH_IDLE;
                end else begin
                    n_scl   = 1'b1;
                    n_phase = i2cmbe_pkg::PH_ST_FALL;
                end
            end
            i2cmbe_pkg::PH_ST_FALL: begin
                n_sda   = 1'b0;
                n_phase = i2cmbe_pkg::PH_ST_CLAMP;
            end
            i2cmbe_pkg::PH_ST_CLAMP: begin
                n_scl   = 1'b0;
                done    = 1'b1;
                n_phase = i2cmbe_pkg::PH_IDLE;
            end
            i2cmbe_pkg::PH_SP_LOW: begin
                n_sda   = 1'b0;
                n_phase = i2cmbe_pkg::PH_SP_HI;
            end
            i2cmbe_pkg::PH_SP_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cmbe_pkg::PH_SP_REL;
            end
            i2cmbe_pkg::PH_SP_REL: begin
                n_sda   = 1'b1;
                done    = 1'b1;
                n_phase = i2cmbe_pkg::PH_IDLE;
            end
            i2cmbe_pkg::PH_WR_SET: begin
                // Drive the MSB and shift the next bit up.
                n_sda       = r_shifter[i2cmbe_pkg::BYTE_W-1];
                n_shifter   = {r_shifter[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
                n_bit_count = r_bit_count + 1'b1;
                n_phase     = i2cmbe_pkg::PH_WR_HI;
            end
            i2cmbe_pkg::PH_WR_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cmbe_pkg::PH_WR_LO;
            end
            i2cmbe_pkg::PH_WR_LO: begin
                n_scl   = 1'b0;
                n_phase = (r_bit_count >= i2cmbe_pkg::BITS_PER_BYTE) ?
                          i2cmbe_pkg::PH_AK_REL : i2cmbe_pkg::PH_WR_SET;
            end
            i2cmbe_pkg::PH_AK_REL: begin
                n_sda   = 1'b1;
                n_phase = i2cmbe_pkg::PH_AK_HI;
            end
            i2cmbe_pkg::PH_AK_HI: begin
                n_scl        = 1'b1;
                n_poll_count = '0;
                n_phase      = i2cmbe_pkg::PH_AK_POLL;
            end
            i2cmbe_pkg::PH_AK_POLL: begin
                // Wait with SCL high for the slave to pull SDA low.
                if (!i_sda_in) begin
                    n_scl   = 1'b0;
                    done    = 1'b1;
                    n_phase = i2cmbe_pkg::PH_IDLE;
                end else if (r_poll_count >= r_poll_limit) begin
                    n_scl         = 1'b0;
                    n_last_status = i2cmbe_pkg::ST_TIMEOUT;
                    n_phase       = i2cmbe_pkg::PH_SP_LOW;
                end else begin
                    n_poll_count = r_poll_count + 1'b1;
                end
            end
            i2cmbe_pkg::PH_RD_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cmbe_pkg::PH_RD_SAMP;
            end
            i2cmbe_pkg::PH_RD_SAMP: begin
                n_shifter   = {r_shifter[i2cmbe_pkg::BYTE_W-2:0], i_sda_in};
                n_bit_count = r_bit_count + 1'b1;
                n_scl       = 1'b0;
                n_phase     = (n_bit_count >= i2cmbe_pkg::BITS_PER_BYTE) ?
                              i2cmbe_pkg::PH_AO_SET : i2cmbe_pkg::PH_RD_HI;
            end
            i2cmbe_pkg::PH_AO_SET: begin
                n_sda   = !r_ack_choice;
                n_phase = i2cmbe_pkg::PH_AO_HI;
            end
            i2cmbe_pkg::PH_AO_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cmbe_pkg::PH_AO_LO;
            end
            i2cmbe_pkg::PH_AO_LO: begin
                n_scl     = 1'b0;
                n_rx_hold = r_shifter;
                done      = 1'b1;
                n_phase   = i2cmbe_pkg::PH_IDLE;
            end
            default: begin
                n_phase = i2cmbe_pkg::PH_IDLE;
            end
        endcase
    end

    // State registers advance once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= i2cmbe_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_shifter     <= '0;
            r_poll_count  <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack_choice  <= 1'b0;
            r_last_status <= i2cmbe_pkg::ST_OK;
            r_rx_hold     <= '0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_shifter     <= n_shifter;
            r_poll_count  <= n_poll_count;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_ack_choice  <= n_ack_choice;
            r_last_status <= n_last_status;
            r_rx_hold     <= n_rx_hold;
        end
    end

    // ACK poll limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= i2cmbe_pkg::POLL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_data;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_scl    <= n_scl;
            r_out_sda    <= n_sda;
            r_out_busy   <= (n_phase != i2cmbe_pkg::PH_IDLE);
            r_out_done   <= done;
            r_out_rx     <= n_rx_hold;
            r_out_status <= rejected ? i2cmbe_pkg::ST_REJECTED : n_last_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_out_scl;
    assign o_sda_level = r_out_sda;
    assign o_busy_res  = r_out_busy;
    assign o_done_res  = r_out_done;
    assign o_rx_byte   = r_out_rx;
    assign o_status    = r_out_status;

    // A completing command always leaves the engine idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("done reported while still busy");

    // Every accepted item leaves a result in the output register.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_valid)
        else $error("accepted item produced no result");

    // The sequencer never reaches an unused phase code.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= i2cmbe_pkg::PH_AO_LO)
        else $error("sequencer phase out of range");

    // The bit counter never passes one byte.
    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= i2cmbe_pkg::BITS_PER_BYTE)
        else $error("bit counter overran one byte");

endmodule

### sim/i2c_bus_tick_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// I2C bus tick checker
// Watches the item, result and configuration ports of the I2C master bit
// engine. It keeps its own copy of the sequencer and predicts the bus levels
// and status for every accepted tick. Each accepted result is compared field
// by field with the oldest prediction.
// ============================================================================
module i2c_bus_tick_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel as seen at the block.
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [i2cmbe_pkg::MODE_W-1:0]     i_mode,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]     i_wr_byte,
    input  logic                              i_send_ack,
    input  logic                              i_sda_in,
    // Result item channel as seen at the block.
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic                              i_scl_level,
    input  logic                              i_sda_level,
    input  logic                              i_busy_res,
    input  logic                              i_done_res,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [i2cmbe_pkg::STATUS_W-1:0]   i_status,
    // Configuration write.
    input  logic                              i_cfg_we,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]     i_cfg_data,
    // Raised once when stimulus is over and all results should be in.
    input  logic                              i_run_end,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_reads,
    output int                                o_timeouts,
    output int                                o_bus_busy,
    output int                                o_rejects
);

    // Levels and status that the block reports for one tick.
    typedef struct packed {
        logic                            scl;
        logic                            sda;
        logic                            busy;
        logic                            done;
        logic [i2cmbe_pkg::BYTE_W-1:0]   rx;
        logic [i2cmbe_pkg::STATUS_W-1:0] status;
    } t_bus_levels;

    t_bus_levels pending_levels[$];

    // Private copy of the engine state and its poll limit.
    logic [i2cmbe_pkg::PHASE_W-1:0]  eng_phase;
    logic [i2cmbe_pkg::COUNT_W-1:0]  bit_cnt;
    logic [i2cmbe_pkg::BYTE_W-1:0]   shift_q;
    logic [i2cmbe_pkg::BYTE_W-1:0]   poll_cnt;
    logic                            scl_q;
    logic                            sda_q;
    logic                            ack_sel_q;
    logic [i2cmbe_pkg::STATUS_W-1:0] last_st;
    logic [i2cmbe_pkg::BYTE_W-1:0]   rx_hold;
    logic [i2cmbe_pkg::BYTE_W-1:0]   poll_limit;

    int fail_cnt   = 0;
    int checked    = 0;
    int reads_done = 0;
    int timeouts   = 0;
    int busy_fails = 0;
    int rejects    = 0;
    bit end_done   = 1'b0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_levels.size();
    assign o_checked    = checked;
    assign o_reads      = reads_done;
    assign o_timeouts   = timeouts;
    assign o_bus_busy   = busy_fails;
    assign o_rejects    = rejects;

    // One line per mismatch; printing stops after a while but counting does not.
    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (fail_cnt < 30)
            $display("MISMATCH result %0d %s: got %0d, expected %0d",
                     checked, what, got_v, want_v);
        fail_cnt++;
    endtask

    task automatic reset_engine();
        eng_phase  = i2cmbe_pkg::PH_IDLE;
        bit_cnt    = '0;
        shift_q    = '0;
        poll_cnt   = '0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        ack_sel_q  = 1'b0;
        last_st    = i2cmbe_pkg::ST_OK;
        rx_hold    = '0;
        poll_limit = i2cmbe_pkg::POLL_LIMIT_RESET;
    endtask

    // Advances the engine copy by one bus tick and returns the levels it shows.
    function automatic t_bus_levels advance_engine(
        input logic [i2cmbe_pkg::MODE_W-1:0] cmd,
        input logic [i2cmbe_pkg::BYTE_W-1:0] tx,
        input logic                          ack_pick,
        input logic                          sda_s);
        t_bus_levels lv;
        logic        fin;
        logic        cmd_seen;
        fin      = 1'b0;
        cmd_seen = (cmd >= i2cmbe_pkg::MODE_START) && (cmd <= i2cmbe_pkg::MODE_READ);
        case (eng_phase)
            i2cmbe_pkg::PH_IDLE: begin
                if (cmd_seen) begin
                    last_st = i2cmbe_pkg::ST_OK;
                    if (cmd == i2cmbe_pkg::MODE_START) begin
                        sda_q     = 1'b1;
                        eng_phase = i2cmbe_pkg::PH_ST_CHECK;
                    end else if (cmd == i2cmbe_pkg::MODE_STOP) begin
                        scl_q     = 1'b0;
                        eng_phase = i2cmbe_pkg::PH_SP_LOW;
                    end else if (cmd == i2cmbe_pkg::MODE_WRITE) begin
                        scl_q     = 1'b0;
                        shift_q   = tx;
                        bit_cnt   = '0;
                        eng_phase = i2cmbe_pkg::PH_WR_SET;
                    end else begin
                        scl_q     = 1'b0;
                        sda_q     = 1'b1;
                        shift_q   = '0;
                        bit_cnt   = '0;
                        ack_sel_q = ack_pick;
                        eng_phase = i2cmbe_pkg::PH_RD_HI;
                    end
                end
                cmd_seen = 1'b0;
            end
            // Start: SDA must be free before the falling edge on SDA.
            i2cmbe_pkg::PH_ST_CHECK: begin
                if (!sda_s) begin
                    last_st   = i2cmbe_pkg::ST_BUS_BUSY;
                    fin       = 1'b1;
                    eng_phase = i2cmbe_pkg::PH_IDLE;
                    busy_fails++;
                end else begin
                    scl_q     = 1'b1;
                    eng_phase = i2cmbe_pkg::PH_ST_FALL;
                end
            end
            i2cmbe_pkg::PH_ST_FALL: begin
                sda_q     = 1'b0;
                eng_phase = i2cmbe_pkg::PH_ST_CLAMP;
            end
            i2cmbe_pkg::PH_ST_CLAMP: begin
                scl_q     = 1'b0;
                fin       = 1'b1;
                eng_phase = i2cmbe_pkg::PH_IDLE;
            end
            // Stop: SDA low, SCL up, then SDA released.
            i2cmbe_pkg::PH_SP_LOW: begin
                sda_q     = 1'b0;
                eng_phase = i2cmbe_pkg::PH_SP_HI;
            end
            i2cmbe_pkg::PH_SP_HI: begin
                scl_q     = 1'b1;
                eng_phase = i2cmbe_pkg::PH_SP_REL;
            end
            i2cmbe_pkg::PH_SP_REL: begin
                sda_q     = 1'b1;
                fin       = 1'b1;
                eng_phase = i2cmbe_pkg::PH_IDLE;
            end
            // Write: one bit per three ticks, MSB first.
            i2cmbe_pkg::PH_WR_SET: begin
                sda_q     = shift_q[i2cmbe_pkg::BYTE_W-1];
                shift_q   = {shift_q[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
                bit_cnt   = bit_cnt + 1'b1;
                eng_phase = i2cmbe_pkg::PH_WR_HI;
            end
            i2cmbe_pkg::PH_WR_HI: begin
                scl_q     = 1'b1;
                eng_phase = i2cmbe_pkg::PH_WR_LO;
            end
            i2cmbe_pkg::PH_WR_LO: begin
                scl_q     = 1'b0;
                eng_phase = (bit_cnt >= i2cmbe_pkg::BITS_PER_BYTE) ?
                            i2cmbe_pkg::PH_AK_REL : i2cmbe_pkg::PH_WR_SET;
            end
            i2cmbe_pkg::PH_AK_REL: begin
                sda_q     = 1'b1;
                eng_phase = i2cmbe_pkg::PH_AK_HI;
            end
            i2cmbe_pkg::PH_AK_HI: begin
                scl_q     = 1'b1;
                poll_cnt  = '0;
                eng_phase = i2cmbe_pkg::PH_AK_POLL;
            end
            // ACK poll with SCL high; past the limit a stop follows.
            i2cmbe_pkg::PH_AK_POLL: begin
                if (!sda_s) begin
                    scl_q     = 1'b0;
                    fin       = 1'b1;
                    eng_phase = i2cmbe_pkg::PH_IDLE;
                end else if (poll_cnt >= poll_limit) begin
                    scl_q     = 1'b0;
                    last_st   = i2cmbe_pkg::ST_TIMEOUT;
                    eng_phase = i2cmbe_pkg::PH_SP_LOW;
                    timeouts++;
                end else begin
                    poll_cnt = poll_cnt + 1'b1;
                end
            end
            // Read: SCL up, then sample and drop SCL.
            i2cmbe_pkg::PH_RD_HI: begin
                scl_q     = 1'b1;
                eng_phase = i2cmbe_pkg::PH_RD_SAMP;
            end
            i2cmbe_pkg::PH_RD_SAMP: begin
                shift_q   = {shift_q[i2cmbe_pkg::BYTE_W-2:0], sda_s};
                bit_cnt   = bit_cnt + 1'b1;
                scl_q     = 1'b0;
                eng_phase = (bit_cnt >= i2cmbe_pkg::BITS_PER_BYTE) ?
                            i2cmbe_pkg::PH_AO_SET : i2cmbe_pkg::PH_RD_HI;
            end
            i2cmbe_pkg::PH_AO_SET: begin
                sda_q     = ~ack_sel_q;
                eng_phase = i2cmbe_pkg::PH_AO_HI;
            end
            i2cmbe_pkg::PH_AO_HI: begin
                scl_q     = 1'b1;
                eng_phase = i2cmbe_pkg::PH_AO_LO;
            end
            i2cmbe_pkg::PH_AO_LO: begin
                scl_q     = 1'b0;
                rx_hold   = shift_q;
                fin       = 1'b1;
                eng_phase = i2cmbe_pkg::PH_IDLE;
                reads_done++;
            end
            default: begin
                eng_phase = i2cmbe_pkg::PH_IDLE;
            end
        endcase
        if (cmd_seen)
            rejects++;
        lv.scl    = scl_q;
        lv.sda    = sda_q;
        lv.busy   = (eng_phase != i2cmbe_pkg::PH_IDLE);
        lv.done   = fin;
        lv.rx     = rx_hold;
        lv.status = cmd_seen ? i2cmbe_pkg::ST_REJECTED : last_st;
        return lv;
    endfunction

    // Compare results first, then predict for the item taken at this edge.
    always @(posedge i_clk) begin : watch
        t_bus_levels got;
        t_bus_levels want;
        if (!i_rst_n) begin
            reset_engine();
            pending_levels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_scl_level, i_sda_level, i_busy_res, i_done_res,
                        i_rx_byte, i_status};
                if (pending_levels.size() == 0) begin
                    report_mismatch("arrived with no tick pending", 1, 0);
                end else begin
                    want = pending_levels.pop_front();
                    if (got.scl !== want.scl)
                        report_mismatch("scl_level", int'(got.scl), int'(want.scl));
                    if (got.sda !== want.sda)
                        report_mismatch("sda_level", int'(got.sda), int'(want.sda));
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", int'(got.busy), int'(want.busy));
                    if (got.done !== want.done)
                        report_mismatch("done_res", int'(got.done), int'(want.done));
                    if (got.rx !== want.rx)
                        report_mismatch("rx_byte", int'(got.rx), int'(want.rx));
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                end
                checked++;
            end
            if (i_in_valid && !i_in_stall)
                pending_levels.push_back(advance_engine(i_mode, i_wr_byte,
                                                        i_send_ack, i_sda_in));
            if (i_cfg_we)
                poll_limit = i_cfg_data;
            if (i_run_end && !end_done) begin
                end_done = 1'b1;
                if (pending_levels.size() != 0)
                    report_mismatch("ticks left without a result",
                                    pending_levels.size(), 0);
            end
        end
    end

endmodule

### sim/i2c_master_bit_engine_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// I2C master bit engine testbench
// Drives bus ticks into the engine: a few directed ticks, then mostly
// well-formed start/write/read/stop frames with random data, ACK timing and
// stray commands, plus bursts of noise. The ACK poll limit is changed between
// phases. A separate checker predicts and compares every result.
// ============================================================================
module i2c_master_bit_engine_top_tb;

    typedef logic [i2cmbe_pkg::MODE_W-1:0]   t_mode;
    typedef logic [i2cmbe_pkg::BYTE_W-1:0]   t_byte;
    typedef logic [i2cmbe_pkg::STATUS_W-1:0] t_status;

    localparam int ITEM_GOAL   = 1150;
    localparam int PHASES      = 6;
    localparam int DRAIN_TICKS = 40;
    localparam int CYCLE_LIMIT = 1000000;
    // Above this limit the ACK on the last allowed sample is not forced.
    localparam int FULL_POLL_MAX = 60;

    // Mode codes that the engine treats as plain ticks.
    localparam t_mode MODE_SPARE_5 = 3'd5;
    localparam t_mode MODE_SPARE_6 = 3'd6;
    localparam t_mode MODE_SPARE_7 = 3'd7;

    logic    i_clk      = 1'b0;
    logic    i_rst_n    = 1'b0;
    logic    i_valid    = 1'b0;
    logic    o_stall;
    t_mode   i_mode     = i2cmbe_pkg::MODE_TICK;
    t_byte   i_wr_byte  = '0;
    logic    i_send_ack = 1'b0;
    logic    i_sda_in   = 1'b1;
    logic    o_valid;
    logic    i_stall    = 1'b0;
    logic    o_scl_level;
    logic    o_sda_level;
    logic    o_busy_res;
    logic    o_done_res;
    t_byte   o_rx_byte;
    t_status o_status;
    logic    i_cfg_we   = 1'b0;
    t_byte   i_cfg_data = '0;
    logic    run_end    = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int reads_seen;
    int timeouts_seen;
    int bus_busy_seen;
    int rejects_seen;

    int cycle_cnt      = 0;
    int item_total     = 0;
    int stall_hold     = 0;
    int stall_pick;
    int poll_limit_now = int'(i2cmbe_pkg::POLL_LIMIT_RESET);
    bit burst_mode     = 1'b0;

    always #2 i_clk = ~i_clk;

    i2c_master_bit_engine_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_wr_byte   (i_wr_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_in    (i_sda_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl_level (o_scl_level),
        .o_sda_level (o_sda_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rx_byte   (o_rx_byte),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    i2c_bus_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_mode       (i_mode),
        .i_wr_byte    (i_wr_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_in     (i_sda_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_scl_level  (o_scl_level),
        .i_sda_level  (o_sda_level),
        .i_busy_res   (o_busy_res),
        .i_done_res   (o_done_res),
        .i_rx_byte    (o_rx_byte),
        .i_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_run_end    (run_end),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_reads      (reads_seen),
        .o_timeouts   (timeouts_seen),
        .o_bus_busy   (bus_busy_seen),
        .o_rejects    (rejects_seen)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_cnt, pending);
            $display("** i2c_master_bit_engine_top: FAILED **");
            $finish;
        end
    end

    // Receiver back-pressure: short stalls, a few long ones, and quiet stretches.
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55) begin
                i_stall    <= 1'b0;
                stall_hold <= $urandom_range(0, 15);
            end else if (stall_pick < 60) begin
                i_stall    <= 1'b0;
                stall_hold <= $urandom_range(50, 200);
            end else if (stall_pick < 95) begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(8, 40);
            end
        end
    end

    function automatic t_byte rand_byte();
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Sender idle time before the next item: mostly none, a few long gaps.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one item and holds it until the engine takes it.
    task automatic push_item(input t_mode m, input t_byte wb,
                             input logic sa, input logic sd, input bit counted);
        int   gap;
        logic held;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= m;
        i_wr_byte  <= wb;
        i_send_ack <= sa;
        i_sda_in   <= sd;
        do begin
            @(negedge i_clk);
            held = o_stall;
            @(posedge i_clk);
        end while (held);
        if (counted)
            item_total++;
    endtask

    // A tick while a command runs; now and then a stray mode code, refused if it is a command.
    task automatic busy_tick(input logic sd);
        t_mode m;
        if ($urandom_range(0, 9) == 0) begin
            m = t_mode'($urandom_range(1, 7));
            push_item(m, rand_byte(), rand_bit(), sd, 1'b1);
        end else begin
            push_item(i2cmbe_pkg::MODE_TICK, rand_byte(), rand_bit(), sd, 1'b1);
        end
    endtask

    task automatic do_start(input logic line_free);
        push_item(i2cmbe_pkg::MODE_START, rand_byte(), rand_bit(), rand_bit(), 1'b1);
        busy_tick(line_free);
        if (line_free)
            repeat (2) busy_tick(rand_bit());
    endtask

    task automatic do_stop();
        push_item(i2cmbe_pkg::MODE_STOP, rand_byte(), rand_bit(), rand_bit(), 1'b1);
        repeat (3) busy_tick(rand_bit());
    endtask

    // Byte out, then the ACK poll: either an ACK after some failed samples,
    // or a timeout followed by the automatic stop.
    task automatic do_write(input t_byte data, input int fails, input bit no_ack);
        push_item(i2cmbe_pkg::MODE_WRITE, data, rand_bit(), rand_bit(), 1'b1);
        repeat (26) busy_tick(rand_bit());
        if (no_ack) begin
            repeat (poll_limit_now + 1) busy_tick(1'b1);
            repeat (3) busy_tick(rand_bit());
        end else begin
            repeat (fails) busy_tick(1'b1);
            busy_tick(1'b0);
        end
    endtask

    task automatic rand_write();
        int r;
        int fails;
        bit no_ack;
        r      = $urandom_range(0, 99);
        no_ack = ($urandom_range(0, 99) < ((poll_limit_now <= 60) ? 8 : 2));
        if (r < 70)
            fails = 0;
        else if (r < 90)
            fails = $urandom_range(1, (poll_limit_now < 3) ? poll_limit_now : 3);
        else
            fails = $urandom_range(0, poll_limit_now);
        do_write(rand_byte(), fails, no_ack);
    endtask

    task automatic do_read(input logic ack_pick);
        push_item(i2cmbe_pkg::MODE_READ, rand_byte(), ack_pick, rand_bit(), 1'b1);
        repeat (19) busy_tick(rand_bit());
    endtask

    // Idle ticks with any tick-only mode code.
    task automatic idle_ticks(input int n);
        t_mode m;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: m = i2cmbe_pkg::MODE_TICK;
                1: m = MODE_SPARE_5;
                2: m = MODE_SPARE_6;
                default: m = MODE_SPARE_7;
            endcase
            push_item(m, rand_byte(), rand_bit(), rand_bit(), 1'b1);
        end
    endtask

    // Ticks with SDA low finish anything in flight (ACK arrives at once).
    task automatic drain_engine();
        repeat (DRAIN_TICKS)
            push_item(i2cmbe_pkg::MODE_TICK, rand_byte(), rand_bit(), 1'b0, 1'b1);
    endtask

    // Input side goes quiet until every pending result has come back.
    task automatic wait_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_poll_limit(input t_byte lim);
        drain_engine();
        wait_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        poll_limit_now = int'(lim);
    endtask

    // One random transaction; mostly complete frames.
    task automatic run_transaction();
        int r;
        int n;
        r          = $urandom_range(0, 99);
        burst_mode = ($urandom_range(0, 3) == 0);
        if (r < 70) begin
            do_start(1'b1);
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 1))
                    rand_write();
                else
                    do_read(rand_bit());
            end
            do_stop();
        end else if (r < 78) begin
            do_start(1'b0);
        end else if (r < 83) begin
            n = $urandom_range(0, 2);
            if (n == 0)
                do_stop();
            else if (n == 1)
                rand_write();
            else
                do_read(rand_bit());
        end else if (r < 90) begin
            idle_ticks($urandom_range(1, 5));
        end else begin
            // Noise: fully random ticks, then a drain back to idle.
            n = $urandom_range(5, 20);
            repeat (n)
                push_item(t_mode'($urandom_range(0, 7)), rand_byte(),
                          rand_bit(), rand_bit(), 1'b1);
            drain_engine();
        end
    endtask

    initial begin : stimulus
        t_byte limits[PHASES];
        limits = '{i2cmbe_pkg::POLL_LIMIT_RESET, 8'd1, 8'd255, 8'd3, 8'd2, 8'd4};
        limits[3] = t_byte'($urandom_range(3, 20));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: tick-only codes at idle with extreme field values.
        push_item(i2cmbe_pkg::MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
        push_item(MODE_SPARE_5, 8'hFF, 1'b1, 1'b1, 1'b1);
        push_item(MODE_SPARE_6, 8'h00, 1'b1, 1'b0, 1'b1);
        push_item(MODE_SPARE_7, 8'hFF, 1'b0, 1'b1, 1'b1);
        // Start while SDA is held low reports a busy bus.
        push_item(i2cmbe_pkg::MODE_START, 8'h00, 1'b0, 1'b0, 1'b1);
        push_item(i2cmbe_pkg::MODE_TICK, 8'hFF, 1'b1, 1'b0, 1'b1);
        // Normal start with commands arriving while it runs; all are refused.
        push_item(i2cmbe_pkg::MODE_START, 8'hFF, 1'b1, 1'b1, 1'b1);
        push_item(i2cmbe_pkg::MODE_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0);
        push_item(i2cmbe_pkg::MODE_READ, 8'h00, 1'b1, 1'b0, 1'b0);
        push_item(i2cmbe_pkg::MODE_STOP, 8'hFF, 1'b0, 1'b1, 1'b0);
        do_stop();

        // Random phases, each under its own ACK poll limit.
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0)
                set_poll_limit(limits[p]);
            // Each limit sees a timeout; small limits also see an ACK on the
            // last allowed sample.
            do_start(1'b1);
            do_write(rand_byte(), 0, 1'b1);
            do_write(rand_byte(), (poll_limit_now > FULL_POLL_MAX) ? 3 : poll_limit_now,
                     1'b0);
            do_stop();
            while (item_total < (p + 1) * ITEM_GOAL / PHASES)
                run_transaction();
        end

        wait_results();
        run_end <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d ticks over %0d poll limits; %0d results checked.",
                 item_total, PHASES, checked);
        $display("Seen: %0d reads, %0d ACK timeouts, %0d busy-bus starts, %0d refused commands.",
                 reads_seen, timeouts_seen, bus_busy_seen, rejects_seen);
        if (fail_count == 0 && pending == 0)
            $display("** i2c_master_bit_engine_top: PASSED **");
        else
            $display("** i2c_master_bit_engine_top: FAILED **");
        $finish;
    end

endmodule

### i2c_master_bit_engine_top.f
rtl/i2cmbe_pkg.sv
rtl/i2c_master_bit_engine_top.sv
sim/i2c_bus_tick_checker.sv
sim/i2c_master_bit_engine_top_tb.sv
